// ===== design/rfg_pkg.sv =====
// rfg_pkg: shared types, register codes and constants for the readout frame generator.
// Used by every module of the block; depends on nothing else.

package rfg_pkg;

  // default number of hit word pairs per frame
  localparam int MAX_HITS_DEF    = 8;
  // trigger queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // filled-pair count is at most 15 (the hit count is four bits), so five bits cover every MAX_HITS
  localparam int FILL_W = 5;

  localparam int BOARD_W   = 5;
  localparam int L1_W      = 32;
  localparam int WORD_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int HITCNT_W  = 4;
  localparam int CHIP_W    = 3;
  localparam int CHAN_W    = 6;

  localparam int STAMP_W   = 16;
  localparam int TAG_W     = 3;
  localparam int RAW_W     = 54;
  localparam int FRAME_W   = 24;
  localparam int CWORD_W   = 18;
  localparam int PKT_W     = 48;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_STATUS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HITCNT  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHIP    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL = 4'd3;

  // register reset values
  localparam logic [STATUS_W-1:0] STATUS_RST  = 3'd2;
  localparam logic [HITCNT_W-1:0] HITCNT_RST  = 4'd8;
  localparam logic [CHIP_W-1:0]   CHIP_RST    = 3'd2;
  localparam logic [CHAN_W-1:0]   CHANNEL_RST = 6'd8;

  // running counter reset values
  localparam logic [RAW_W-1:0]   RAW_RST   = 54'h123456876543;
  localparam logic [CWORD_W-1:0] CWORD_RST = 18'h05678;

  // word tags in the top bits
  localparam logic [2:0] HDR_TAG = 3'b110;
  localparam logic [2:0] TRL_TAG = 3'b111;
  localparam logic [1:0] SEQ_TAG = 2'b01;

  typedef struct packed {
    logic [STATUS_W-1:0] stat_flags;
    logic [HITCNT_W-1:0] hit_pairs;
    logic [CHIP_W-1:0]   chip_id;
    logic [CHAN_W-1:0]   channel_id;
  } cfg_t;

  // one queued trigger with its filled-pair count already worked out
  typedef struct packed {
    logic [BOARD_W-1:0] board_id;
    logic [L1_W-1:0]    l1_count;
    logic [FILL_W-1:0]  filled;
  } trig_t;

endpackage

// ===== design/rfg_front.sv =====
// rfg_front: trigger intake stage; registers one trigger and clamps the hit count.
// Depends on rfg_pkg; feeds rfg_queue.

module rfg_front #(
  parameter int MAX_HITS = rfg_pkg::MAX_HITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rfg_pkg::BOARD_W-1:0]  in_board_id,
  input  logic [rfg_pkg::L1_W-1:0]     in_l1_count,
  input  logic [rfg_pkg::HITCNT_W-1:0] hit_pairs,
  output logic                         push_valid,
  input  logic                         push_ready,
  output rfg_pkg::trig_t               push_entry
);

  localparam logic [rfg_pkg::FILL_W-1:0] MAX_FILL = rfg_pkg::FILL_W'(MAX_HITS);

  logic                         stage_valid_r;
  rfg_pkg::trig_t               stage_r;
  logic                         accept;
  logic [rfg_pkg::FILL_W-1:0]   hc_ext;
  rfg_pkg::trig_t               stage_nxt;

  assign in_stall   = stage_valid_r && !push_ready;
  assign accept     = in_valid && !in_stall;
  assign push_valid = stage_valid_r;
  assign push_entry = stage_r;

  assign hc_ext = rfg_pkg::FILL_W'(hit_pairs);

  always_comb begin
    stage_nxt.board_id = in_board_id;
    stage_nxt.l1_count = in_l1_count;
    stage_nxt.filled   = (hc_ext > MAX_FILL) ? MAX_FILL : hc_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (accept) begin
      stage_valid_r <= 1'b1;
    end else if (push_ready) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

// ===== design/rfg_queue.sv =====
// rfg_queue: short trigger queue between the intake stage and the frame sequencer.
// Depends on rfg_pkg for the entry type.

module rfg_queue #(
  parameter int DEPTH = rfg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rfg_pkg::trig_t push_entry,
  output logic           pop_valid,
  input  logic           pop,
  output rfg_pkg::trig_t pop_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rfg_pkg::trig_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_entry  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== design/rfg_back.sv =====
// rfg_back: frame sequencer; walks the frame word by word, owns the running counters
// and the output register. Depends on rfg_pkg; pops triggers from rfg_queue.

module rfg_back #(
  parameter int MAX_HITS = rfg_pkg::MAX_HITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rfg_pkg::cfg_t               cfg,
  input  logic                        q_valid,
  input  rfg_pkg::trig_t              q_entry,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rfg_pkg::WORD_W-1:0]  out_word,
  output logic                        out_last
);

  localparam int FRAME_WORDS = 2 * MAX_HITS + 6;
  localparam int POS_W       = $clog2(FRAME_WORDS);
  localparam logic [POS_W-1:0] POS_H1   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HEND = POS_W'(2 * MAX_HITS + 2);
  localparam logic [POS_W-1:0] POS_T0   = POS_W'(FRAME_WORDS - 4);
  localparam logic [POS_W-1:0] POS_T1   = POS_W'(FRAME_WORDS - 3);
  localparam logic [POS_W-1:0] POS_S0   = POS_W'(FRAME_WORDS - 2);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_WORDS - 1);

  typedef enum logic [2:0] {
    WK_H0, WK_H1, WK_HA, WK_HB, WK_T0, WK_T1, WK_S0, WK_S1
  } kind_t;

  logic                           busy_r;
  logic [POS_W-1:0]               pos_r;
  rfg_pkg::trig_t                 cur_r;
  logic [rfg_pkg::FILL_W-1:0]     hits_left_r;

  logic [rfg_pkg::STAMP_W-1:0]    stamp_r;
  logic [rfg_pkg::TAG_W-1:0]      tag_r;
  logic [rfg_pkg::RAW_W-1:0]      raw_r;
  logic [rfg_pkg::FRAME_W-1:0]    frame_r;
  logic [rfg_pkg::CWORD_W-1:0]    cword_r;
  logic [rfg_pkg::PKT_W-1:0]      pkt_r;

  logic                           out_valid_r, out_last_r;
  logic [rfg_pkg::WORD_W-1:0]     out_word_r;

  kind_t                          kind;
  logic                           adv, emit, load, at_last, pair_on;
  logic [rfg_pkg::RAW_W-1:0]      raw_nxt;
  logic [rfg_pkg::WORD_W-1:0]     word_nxt;

  assign adv     = !out_valid_r || !out_stall;
  assign emit    = adv && busy_r;
  assign at_last = (pos_r == POS_LAST);
  // next trigger is picked up on the last word so frames run back to back
  assign load    = adv && q_valid && (!busy_r || at_last);
  assign q_pop   = load;
  assign pair_on = (hits_left_r != '0);
  assign raw_nxt = raw_r + 1'b1;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

  always_comb begin
    if (pos_r == '0) begin
      kind = WK_H0;
    end else if (pos_r == POS_H1) begin
      kind = WK_H1;
    end else if (pos_r < POS_HEND) begin
      kind = pos_r[0] ? WK_HB : WK_HA;
    end else if (pos_r == POS_T0) begin
      kind = WK_T0;
    end else if (pos_r == POS_T1) begin
      kind = WK_T1;
    end else if (pos_r == POS_S0) begin
      kind = WK_S0;
    end else begin
      kind = WK_S1;
    end
  end

  always_comb begin
    unique case (kind)
      WK_H0: word_nxt = {rfg_pkg::HDR_TAG, cfg.stat_flags, cur_r.l1_count[31:6]};
      WK_H1: word_nxt = {2'b00, cur_r.l1_count[5:0], 4'b0000, cfg.hit_pairs, stamp_r};
      WK_HA: word_nxt = pair_on ? {2'b00, cfg.chip_id, tag_r, raw_nxt[53:30]} : '0;
      WK_HB: word_nxt = pair_on ? {2'b00, raw_r[29:0]} : '0;
      WK_T0: word_nxt = {rfg_pkg::TRL_TAG, frame_r, cur_r.board_id};
      WK_T1: word_nxt = {2'b00, cfg.chip_id, cur_r.l1_count[2:0], cfg.channel_id, cword_r};
      WK_S0: word_nxt = {rfg_pkg::SEQ_TAG, 5'b00000, cur_r.board_id, pkt_r[47:28]};
      WK_S1: word_nxt = {rfg_pkg::SEQ_TAG, 2'b00, pkt_r[27:0]};
      default: word_nxt = '0;
    endcase
  end

  // sequencer control and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pos_r       <= '0;
      hits_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= busy_r;
      end
      if (load) begin
        busy_r      <= 1'b1;
        pos_r       <= '0;
        hits_left_r <= q_entry.filled;
      end else if (emit) begin
        pos_r <= pos_r + 1'b1;
        if (at_last) begin
          busy_r <= 1'b0;
        end
        if (kind == WK_HB && pair_on) begin
          hits_left_r <= hits_left_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_entry;
    end
    if (adv) begin
      out_word_r <= word_nxt;
      out_last_r <= at_last;
    end
  end

  // running counters, each bumped once per frame on a fixed word, the raw count once per filled hit pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r <= '0;
      tag_r   <= '0;
      raw_r   <= rfg_pkg::RAW_RST;
      frame_r <= '0;
      cword_r <= rfg_pkg::CWORD_RST;
      pkt_r   <= '0;
    end else if (emit) begin
      case (kind)
        WK_H1: stamp_r <= stamp_r + 1'b1;
        WK_HA: begin
          if (pair_on) begin
            raw_r <= raw_nxt;
          end
        end
        WK_T0: begin
          frame_r <= frame_r + 1'b1;
          tag_r   <= tag_r + 1'b1;
        end
        WK_T1: cword_r <= cword_r + 1'b1;
        WK_S1: pkt_r   <= pkt_r + 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/readout_frame_generator.sv =====
// readout_frame_generator: top level; config registers, intake stage, trigger queue
// and frame sequencer. Depends on rfg_pkg, rfg_front, rfg_queue, rfg_back.

// Each accepted trigger yields one frame of 2*MAX_HITS+6 32-bit words (22 at the
// default), one word per cycle from the output register while out_stall is low,
// with out_last on the final word; frames follow with no gap when the next trigger
// is already queued. Triggers are taken into an intake register and a
// QUEUE_DEPTH-entry queue while an earlier frame is still being sent; in_stall
// rises only when both are full. When idle, a trigger passes the intake register
// and the queue into the sequencer before its first word is registered at the
// output. Config registers take writes every cycle (cfg_ready is always high) and
// should only be written while no frame is pending; unknown indexes are ignored.

module readout_frame_generator #(
  parameter int MAX_HITS    = rfg_pkg::MAX_HITS_DEF,
  parameter int QUEUE_DEPTH = rfg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rfg_pkg::BOARD_W-1:0]    in_board_id,
  input  logic [rfg_pkg::L1_W-1:0]       in_l1_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rfg_pkg::WORD_W-1:0]     out_word,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rfg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfg_pkg::CFG_DATA_W-1:0] cfg_data
);

  rfg_pkg::cfg_t  cfg_r;
  logic           push_valid, push_ready;
  rfg_pkg::trig_t push_entry;
  logic           q_valid, q_pop;
  rfg_pkg::trig_t q_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stat_flags <= rfg_pkg::STATUS_RST;
      cfg_r.hit_pairs  <= rfg_pkg::HITCNT_RST;
      cfg_r.chip_id    <= rfg_pkg::CHIP_RST;
      cfg_r.channel_id <= rfg_pkg::CHANNEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rfg_pkg::REG_STATUS:  cfg_r.stat_flags <= cfg_data[rfg_pkg::STATUS_W-1:0];
        rfg_pkg::REG_HITCNT:  cfg_r.hit_pairs  <= cfg_data[rfg_pkg::HITCNT_W-1:0];
        rfg_pkg::REG_CHIP:    cfg_r.chip_id    <= cfg_data[rfg_pkg::CHIP_W-1:0];
        rfg_pkg::REG_CHANNEL: cfg_r.channel_id <= cfg_data[rfg_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  rfg_front #(.MAX_HITS(MAX_HITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_board_id(in_board_id),
    .in_l1_count(in_l1_count),
    .hit_pairs  (cfg_r.hit_pairs),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  rfg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_entry(push_entry),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_entry (q_entry)
  );

  rfg_back #(.MAX_HITS(MAX_HITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .out_last (out_last)
  );

endmodule

// ===== design/rfg_checker.sv =====
// rfg_checker: port-level checks on stall holding, frame length and framing of the result channel.
// Depends on rfg_pkg; bound to readout_frame_generator at the end of this file.

module rfg_checker #(
  parameter int MAX_HITS = rfg_pkg::MAX_HITS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [rfg_pkg::WORD_W-1:0] out_word,
  input logic                       out_last
);

  localparam int FRAME_WORDS = 2 * MAX_HITS + 6;
  localparam int POS_W       = $clog2(FRAME_WORDS);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_WORDS - 1);

  logic [POS_W-1:0] beat_cnt_r;
  logic             beat;

  assign beat = out_valid && !out_stall;

  // word position within the current frame, as seen on the port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_cnt_r <= '0;
    end else if (beat) begin
      beat_cnt_r <= out_last ? '0 : beat_cnt_r + 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_length: assert property (@(posedge clk) disable iff (!rst_n)
    beat |-> (out_last == (beat_cnt_r == POS_LAST)))
    else $error("frame last flag not on the final word");

  a_header: assert property (@(posedge clk) disable iff (!rst_n)
    beat && beat_cnt_r == '0 |-> out_word[31:29] == rfg_pkg::HDR_TAG)
    else $error("frame does not open with a header word");

  a_tail: assert property (@(posedge clk) disable iff (!rst_n)
    beat && out_last |-> out_word[31:28] == {rfg_pkg::SEQ_TAG, 2'b00})
    else $error("frame does not close with a sequence word");

endmodule

bind readout_frame_generator rfg_checker #(.MAX_HITS(MAX_HITS)) u_rfg_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word),
  .out_last (out_last)
);

// ===== tb/sv/tb_readout_frame_generator.sv =====
// tb_readout_frame_generator: self-checking testbench for the readout frame generator.
// Directed table and random phases with a frame predictor; depends on rfg_pkg and the
// readout_frame_generator RTL.
`timescale 1ns / 100ps

module tb_readout_frame_generator;

  localparam int MAX_HITS    = rfg_pkg::MAX_HITS_DEF;
  localparam int FRAME_WORDS = 2 * MAX_HITS + 6;
  localparam int NUM_DIR_ROWS = 25;
  localparam int NUM_PHASES   = 7;
  localparam int PHASE_TRIGS  = 64;
  localparam int BURST_TRIGS  = 12;
  localparam int LONG_HOLD    = 220;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 30;
  localparam int MAX_REPORTS   = 10;

  // indexes with no register behind them
  localparam logic [rfg_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd4;
  localparam logic [rfg_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

  typedef enum logic {ROW_TRIGGER, ROW_REG_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [rfg_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [rfg_pkg::CFG_DATA_W-1:0] reg_data;
    logic [rfg_pkg::BOARD_W-1:0]    board;
    logic [rfg_pkg::L1_W-1:0]       l1;
    logic                           has_word;
    logic [4:0]                     word_pos;
    logic [rfg_pkg::WORD_W-1:0]     word_value;
  } dir_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [rfg_pkg::BOARD_W-1:0]    in_board_id;
  logic [rfg_pkg::L1_W-1:0]       in_l1_count;
  logic                           out_valid;
  logic                           out_stall;
  logic [rfg_pkg::WORD_W-1:0]     out_word;
  logic                           out_last;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [rfg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rfg_pkg::CFG_DATA_W-1:0] cfg_data;

  // predictor state
  rfg_pkg::cfg_t                shadow_cfg;
  logic [rfg_pkg::STAMP_W-1:0] hdr_stamp;
  logic [rfg_pkg::TAG_W-1:0]   hit_tag;
  logic [rfg_pkg::RAW_W-1:0]   raw_count;
  logic [rfg_pkg::FRAME_W-1:0] trl_frame_no;
  logic [rfg_pkg::CWORD_W-1:0] trl_count_word;
  logic [rfg_pkg::PKT_W-1:0]   seq_packet_no;

  logic [rfg_pkg::WORD_W-1:0] exp_frame_word[$];
  logic                       exp_frame_last[$];

  int mismatch_count = 0;
  int sender_gap_pct = 0;
  int receiver_stall_pct = 0;
  int hold_request = 0;

  dir_row_t dir_rows [NUM_DIR_ROWS];

  always #6 clk = ~clk;

  readout_frame_generator i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_board_id (in_board_id),
    .in_l1_count (in_l1_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .out_last    (out_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // zero in (100 - pct) percent of calls, else short, now and then long
  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(30, 10);
    return $urandom_range(3, 1);
  endfunction

  task automatic note_mismatch(input string what, input logic [rfg_pkg::WORD_W-1:0] want,
                               input logic [rfg_pkg::WORD_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t mismatch on %s: expected %08h, got %08h", $realtime, what, want, got);
    end
  endtask

  // expected words of one frame, counters advanced as the block does
  task automatic build_frame(input logic [rfg_pkg::BOARD_W-1:0] board,
                             input logic [rfg_pkg::L1_W-1:0] l1);
    int filled;
    int h;
    logic [rfg_pkg::WORD_W-1:0] words[$];
    filled = (shadow_cfg.hit_pairs > MAX_HITS) ? MAX_HITS : int'(shadow_cfg.hit_pairs);
    words.push_back({rfg_pkg::HDR_TAG, shadow_cfg.stat_flags, l1[rfg_pkg::L1_W-1:6]});
    words.push_back({2'b00, l1[5:0], 4'b0000, shadow_cfg.hit_pairs, hdr_stamp});
    hdr_stamp++;
    for (h = 0; h < MAX_HITS; h++) begin
      if (h < filled) begin
        raw_count++;
        words.push_back({2'b00, shadow_cfg.chip_id, hit_tag,
                         raw_count[rfg_pkg::RAW_W-1:30]});
        words.push_back({2'b00, raw_count[29:0]});
      end else begin
        words.push_back(32'h0);
        words.push_back(32'h0);
      end
    end
    hit_tag++;
    words.push_back({rfg_pkg::TRL_TAG, trl_frame_no, board});
    trl_frame_no++;
    words.push_back({2'b00, shadow_cfg.chip_id, l1[2:0], shadow_cfg.channel_id,
                     trl_count_word});
    trl_count_word++;
    words.push_back({rfg_pkg::SEQ_TAG, 5'b00000, board,
                     seq_packet_no[rfg_pkg::PKT_W-1:28]});
    words.push_back({rfg_pkg::SEQ_TAG, 2'b00, seq_packet_no[27:0]});
    seq_packet_no++;
    for (h = 0; h < words.size(); h++) begin
      exp_frame_word.push_back(words[h]);
      exp_frame_last.push_back(h == words.size() - 1);
    end
  endtask

  task automatic drive_trigger(input logic [rfg_pkg::BOARD_W-1:0] board,
                               input logic [rfg_pkg::L1_W-1:0] l1);
    int gap;
    gap = pick_gap(sender_gap_pct);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_board_id <= board;
    in_l1_count <= l1;
    do @(posedge clk); while (in_stall);
    build_frame(board, l1);
  endtask

  // stop offering and wait until every frame has left the block
  task automatic drain_frames();
    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_frame_word.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rfg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rfg_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rfg_pkg::REG_STATUS:  shadow_cfg.stat_flags = data[rfg_pkg::STATUS_W-1:0];
      rfg_pkg::REG_HITCNT:  shadow_cfg.hit_pairs  = data[rfg_pkg::HITCNT_W-1:0];
      rfg_pkg::REG_CHIP:    shadow_cfg.chip_id    = data[rfg_pkg::CHIP_W-1:0];
      rfg_pkg::REG_CHANNEL: shadow_cfg.channel_id = data[rfg_pkg::CHAN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [rfg_pkg::BOARD_W-1:0] rand_board();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return rfg_pkg::BOARD_W'($urandom_range(31));
    endcase
  endfunction

  function automatic logic [rfg_pkg::L1_W-1:0] rand_l1();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // register value in the low bits, junk above that the block must drop
  function automatic logic [rfg_pkg::CFG_DATA_W-1:0] with_junk(input int value,
                                                                input int width);
    logic [rfg_pkg::CFG_DATA_W-1:0] data;
    data = rfg_pkg::CFG_DATA_W'($urandom_range(255));
    data = (data >> width << width) | rfg_pkg::CFG_DATA_W'(value);
    return data;
  endfunction

  // result side: random stalls, plus one long hold on request
  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        n = pick_gap(receiver_stall_pct);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : out_check
    logic [rfg_pkg::WORD_W-1:0] want_word;
    logic                       want_last;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_frame_word.size() == 0) begin
        note_mismatch("beat with no frame pending", 32'h0, out_word);
      end else begin
        want_word = exp_frame_word.pop_front();
        want_last = exp_frame_last.pop_front();
        if (out_word !== want_word) note_mismatch("out_word", want_word, out_word);
        if (out_last !== want_last) begin
          note_mismatch("out_last", {31'b0, want_last}, {31'b0, out_last});
        end
      end
    end
  end

  // reports failure and stops the run if it is still going well past its slowest legal length
  initial begin : watchdog
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int r;
    int phase;
    int k;
    int hits;
    dir_row_t row;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_board_id = '0;
    in_l1_count = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;

    shadow_cfg     = '{rfg_pkg::STATUS_RST, rfg_pkg::HITCNT_RST, rfg_pkg::CHIP_RST,
                       rfg_pkg::CHANNEL_RST};
    hdr_stamp      = '0;
    hit_tag        = '0;
    raw_count      = rfg_pkg::RAW_RST;
    trl_frame_no   = '0;
    trl_count_word = rfg_pkg::CWORD_RST;
    seq_packet_no  = '0;

    dir_rows = '{
      '{ROW_TRIGGER, rfg_pkg::REG_STATUS, 8'h00, 5'd0, 32'h0000_0000, 1'b1, 5'd0, 32'hC800_0000},
      '{ROW_TRIGGER, rfg_pkg::REG_STATUS, 8'h00, 5'd31, 32'hFFFF_FFFF, 1'b1, 5'd0, 32'hCBFF_FFFF},
      '{ROW_TRIGGER, rfg_pkg::REG_STATUS, 8'h00, 5'd31, 32'h0000_003F, 1'b1, 5'd20, 32'h41F0_0000},
      '{ROW_REG_WRITE, rfg_pkg::REG_STATUS, 8'hFF, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0},
      '{ROW_TRIGGER, rfg_pkg::REG_STATUS, 8'h00, 5'd21, 32'hAAAA_AAAA, 1'b1, 5'd0, 32'hDEAA_AAAA},
      '{ROW_REG_WRITE, rfg_pkg::REG_STATUS, 8'hF8, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0},
      '{ROW_TRIGGER, rfg_pkg::REG_STATUS, 8'h00, 5'd10, 32'h5555_5555, 1'b1, 5'd0, 32'hC155_5555},
      // no hits: every hit slot reads zero
      '{ROW_REG_WRITE, rfg_pkg::REG_HITCNT, 8'h00, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0},
      '{ROW_TRIGGER, rfg_pkg::REG_STATUS, 8'h00, 5'd1, 32'h1234_5678, 1'b1, 5'd2, 32'h0},
      // hit count past the slot count: all slots filled, header keeps raw value
      '{ROW_REG_WRITE, rfg_pkg::REG_HITCNT, 8'hFF, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0},
      '{ROW_TRIGGER, rfg_pkg::REG_STATUS, 8'h00, 5'd2, 32'h8765_4321, 1'b0, 5'd0, 32'h0},
      '{ROW_REG_WRITE, rfg_pkg::REG_HITCNT, 8'h09, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0},
      '{ROW_TRIGGER, rfg_pkg::REG_STATUS, 8'h00, 5'd3, 32'h0F0F_0F0F, 1'b0, 5'd0, 32'h0},
      '{ROW_REG_WRITE, rfg_pkg::REG_HITCNT, 8'h01, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0},
      '{ROW_TRIGGER, rfg_pkg::REG_STATUS, 8'h00, 5'd4, 32'hF0F0_F0F0, 1'b1, 5'd4, 32'h0},
      '{ROW_REG_WRITE, rfg_pkg::REG_CHIP, 8'h07, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0},
      '{ROW_REG_WRITE, rfg_pkg::REG_CHANNEL, 8'h3F, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0},
      '{ROW_TRIGGER, rfg_pkg::REG_STATUS, 8'h00, 5'd31, 32'h0000_0007, 1'b0, 5'd0, 32'h0},
      '{ROW_REG_WRITE, rfg_pkg::REG_CHIP, 8'h00, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0},
      '{ROW_REG_WRITE, rfg_pkg::REG_CHANNEL, 8'hC0, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0},
      '{ROW_TRIGGER, rfg_pkg::REG_STATUS, 8'h00, 5'd0, 32'hFFFF_FFF8, 1'b0, 5'd0, 32'h0},
      // writes to empty indexes change nothing
      '{ROW_REG_WRITE, REG_UNUSED_LO, 8'hFF, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0},
      '{ROW_REG_WRITE, REG_UNUSED_HI, 8'h5A, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0},
      '{ROW_TRIGGER, rfg_pkg::REG_STATUS, 8'h00, 5'd1, 32'h0000_0040, 1'b1, 5'd0, 32'hC000_0001},
      '{ROW_REG_WRITE, rfg_pkg::REG_HITCNT, 8'h08, 5'd0, 32'h0, 1'b0, 5'd0, 32'h0}
    };

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed rows, back-to-back with a light stall load
    receiver_stall_pct = 20;
    for (r = 0; r < NUM_DIR_ROWS; r++) begin
      row = dir_rows[r];
      if (row.kind == ROW_REG_WRITE) begin
        drain_frames();
        write_reg(row.reg_index, row.reg_data);
      end else begin
        drive_trigger(row.board, row.l1);
        if (row.has_word) begin
          exp_frame_word[exp_frame_word.size() - FRAME_WORDS + row.word_pos] = row.word_value;
        end
      end
    end

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain_frames();
      case (phase)
        0: hits = 0;
        1: hits = 15;
        2: hits = MAX_HITS;
        default: hits = ($urandom_range(3) == 0) ? $urandom_range(15, 9)
                                                  : $urandom_range(MAX_HITS, 1);
      endcase
      if (phase == 0) begin
        write_reg(rfg_pkg::REG_STATUS,  with_junk(0, rfg_pkg::STATUS_W));
        write_reg(rfg_pkg::REG_CHIP,    with_junk(0, rfg_pkg::CHIP_W));
        write_reg(rfg_pkg::REG_CHANNEL, with_junk(0, rfg_pkg::CHAN_W));
      end else if (phase == 1) begin
        write_reg(rfg_pkg::REG_STATUS,  with_junk(7, rfg_pkg::STATUS_W));
        write_reg(rfg_pkg::REG_CHIP,    with_junk(7, rfg_pkg::CHIP_W));
        write_reg(rfg_pkg::REG_CHANNEL, with_junk(63, rfg_pkg::CHAN_W));
      end else begin
        write_reg(rfg_pkg::REG_STATUS,  with_junk($urandom_range(7), rfg_pkg::STATUS_W));
        write_reg(rfg_pkg::REG_CHIP,    with_junk($urandom_range(7), rfg_pkg::CHIP_W));
        write_reg(rfg_pkg::REG_CHANNEL, with_junk($urandom_range(63), rfg_pkg::CHAN_W));
      end
      write_reg(rfg_pkg::REG_HITCNT, with_junk(hits, rfg_pkg::HITCNT_W));
      if ($urandom_range(1) == 0) begin
        write_reg(rfg_pkg::CFG_IDX_W'($urandom_range(15, 4)),
                  rfg_pkg::CFG_DATA_W'($urandom_range(255)));
      end

      sender_gap_pct     = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 25 : 60;
      receiver_stall_pct = ((phase + 1) % 3 == 0) ? 0 : ((phase + 1) % 3 == 1) ? 20 : 50;

      // receiver holds off while the sender keeps offering, so the input stalls
      if (phase == 3) begin
        hold_request = LONG_HOLD;
        k = sender_gap_pct;
        sender_gap_pct = 0;
        for (r = 0; r < BURST_TRIGS; r++) drive_trigger(rand_board(), rand_l1());
        sender_gap_pct = k;
      end

      for (r = 0; r < PHASE_TRIGS; r++) drive_trigger(rand_board(), rand_l1());
    end

    drain_frames();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && exp_frame_word.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
